[src/bfr_pkg.sv]
package bfr_pkg;

    // Store and glyph bounds
    localparam int ATLAS_PIXELS     = 16384;
    localparam int MAX_GLYPH_WIDTH  = 8;
    localparam int MAX_GLYPH_HEIGHT = 8;
    localparam int ATLAS_AW = $clog2(ATLAS_PIXELS);
    localparam int GX_W = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
    localparam int GY_W = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character codes that only move the cursor
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam int TAB_CELLS = 4;

    typedef struct packed {
        logic [15:0] origin_column;
        logic [15:0] origin_row;
        logic [12:0] frame_width;
        logic [3:0]  glyph_width;
        logic [3:0]  glyph_height;
        logic [8:0]  tiles_across;
        logic [11:0] atlas_width;
        logic [31:0] ink_colour;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        origin_column: 16'd0,
        origin_row:    16'd0,
        frame_width:   13'd640,
        glyph_width:   4'd8,
        glyph_height:  4'd8,
        tiles_across:  9'd16,
        atlas_width:   12'd128,
        ink_colour:    32'hFFFF_FFFF
    };

    typedef enum logic {
        CMD_LOAD,
        CMD_DRAW
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [ATLAS_AW-1:0]   atlas_addr;
        logic                  atlas_bit;
        logic [15:0]           col;
        logic [15:0]           row;
        logic [ATLAS_AW-1:0]   base;
    } cmd_t;

    // Clamp glyph size to the supported cell
    function automatic logic [3:0] sat_width(input logic [3:0] w);
        sat_width = (w > 4'(MAX_GLYPH_WIDTH)) ? 4'(MAX_GLYPH_WIDTH) : w;
    endfunction

    function automatic logic [3:0] sat_height(input logic [3:0] h);
        sat_height = (h > 4'(MAX_GLYPH_HEIGHT)) ? 4'(MAX_GLYPH_HEIGHT) : h;
    endfunction

endpackage

[src/bitmap_font_text_rasterizer.sv]
// Bitmap font text rasterizer.
// Input stream (s_): one request per item. s_tuser selects the kind: 0 writes
// one pixel of the one-bit glyph atlas, 1 handles one character. Newline,
// return and tab only move the text cursor; any other byte draws its glyph
// tile as one output request per cell pixel, row-major, with tlast on the
// final pixel, and moves the cursor right by one cell width plus one.
// Output stream (m_): framebuffer writes; tuser is the write enable (ink bit).
// Throughput: one pixel per cycle while m_tready is high. The pixel sequencer
// pops a draw command and then walks its cell, which sets the character rate.
// The front takes loads and cursor moves back to back and, for a draw, runs
// the tile lookup (divide, multiply, push) before it takes a new item; this is
// overlapped with drawing the previous glyph through a four-entry command queue.
// Stall: a low m_tready freezes the pixel pipeline; the queue then fills and
// s_tready drops. Reset clears cursor, queue and pipeline and loads register
// defaults; the atlas keeps no reset and must be loaded before use.
// Configuration (APB, 32-bit, registers at 4*i) must be written only while
// idle; the block itself does not enforce this.
module bitmap_font_text_rasterizer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // atlas_address[13:0], atlas_bit, char_code[7:0], restart_text
    input  logic        s_tuser,   // action
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_address[23:0], pixel_colour[31:0]
    output logic        m_tuser,   // write_enable
    output logic        m_tlast
);
    import bfr_pkg::*;

    typedef enum logic [2:0] {
        REG_ORIGIN_COLUMN,
        REG_ORIGIN_ROW,
        REG_FRAME_WIDTH,
        REG_GLYPH_WIDTH,
        REG_GLYPH_HEIGHT,
        REG_TILES_ACROSS,
        REG_ATLAS_WIDTH,
        REG_INK_COLOUR
    } reg_index_t;

    cfg_t        cfg_reg, cfg_next;
    reg_index_t  reg_idx;
    logic        cfg_write;

    logic        q_push;
    cmd_t        q_push_data;
    logic        q_full;
    logic        q_pop;
    cmd_t        q_pop_data;
    logic        q_empty;

    logic [23:0] pixel_address;
    logic [31:0] pixel_colour;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                REG_ORIGIN_COLUMN: cfg_next.origin_column = pwdata[15:0];
                REG_ORIGIN_ROW:    cfg_next.origin_row    = pwdata[15:0];
                REG_FRAME_WIDTH:   cfg_next.frame_width   = pwdata[12:0];
                REG_GLYPH_WIDTH:   cfg_next.glyph_width   = pwdata[3:0];
                REG_GLYPH_HEIGHT:  cfg_next.glyph_height  = pwdata[3:0];
                REG_TILES_ACROSS:  cfg_next.tiles_across  = pwdata[8:0];
                REG_ATLAS_WIDTH:   cfg_next.atlas_width   = pwdata[11:0];
                REG_INK_COLOUR:    cfg_next.ink_colour    = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_COLUMN: prdata = 32'(cfg_reg.origin_column);
            REG_ORIGIN_ROW:    prdata = 32'(cfg_reg.origin_row);
            REG_FRAME_WIDTH:   prdata = 32'(cfg_reg.frame_width);
            REG_GLYPH_WIDTH:   prdata = 32'(cfg_reg.glyph_width);
            REG_GLYPH_HEIGHT:  prdata = 32'(cfg_reg.glyph_height);
            REG_TILES_ACROSS:  prdata = 32'(cfg_reg.tiles_across);
            REG_ATLAS_WIDTH:   prdata = 32'(cfg_reg.atlas_width);
            REG_INK_COLOUR:    prdata = cfg_reg.ink_colour;
            default:           prdata = '0;
        endcase
    end

    bfr_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_action        (s_tuser),
        .s_atlas_address (s_tdata[13:0]),
        .s_atlas_bit     (s_tdata[14]),
        .s_char_code     (s_tdata[22:15]),
        .s_restart_text  (s_tdata[23]),
        .q_push          (q_push),
        .q_push_data     (q_push_data),
        .q_full          (q_full)
    );

    bfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    bfr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_pop           (q_pop),
        .q_pop_data      (q_pop_data),
        .q_empty         (q_empty),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_pixel_address (pixel_address),
        .m_write_enable  (m_tuser),
        .m_pixel_colour  (pixel_colour),
        .m_last_of_glyph (m_tlast)
    );

    assign m_tdata = {pixel_colour, pixel_address};

endmodule

[src/bfr_queue.sv]
module bfr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bfr_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output bfr_pkg::cmd_t  pop_data,
    output logic           empty
);
    import bfr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/bfr_front.sv]
module bfr_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  bfr_pkg::cfg_t  cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_action,
    input  logic [13:0]    s_atlas_address,
    input  logic           s_atlas_bit,
    input  logic [7:0]     s_char_code,
    input  logic           s_restart_text,
    output logic           q_push,
    output bfr_pkg::cmd_t  q_push_data,
    input  logic           q_full
);
    import bfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_PUSH
    } state_t;

    state_t       state_reg, state_next;
    logic [15:0]  col_reg, col_next;
    logic [15:0]  row_reg, row_next;
    logic [15:0]  draw_col_reg, draw_col_next;
    logic [15:0]  draw_row_reg, draw_row_next;
    logic [7:0]   code_reg, code_next;
    logic [7:0]   code_sh_reg, code_sh_next;
    logic [8:0]   rem_reg, rem_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [11:0]  prod_reg, prod_next;

    logic         accept;
    logic [3:0]   gw;
    logic [3:0]   gh;
    logic [4:0]   gw_p1;
    logic [4:0]   gh_p1;
    logic [8:0]   tiles;
    logic [15:0]  cur_col;
    logic [15:0]  cur_row;
    logic [9:0]   trial;
    logic [7:0]   tile_x;
    logic [7:0]   diff;
    logic [15:0]  base_full;

    assign gw    = sat_width(cfg.glyph_width);
    assign gh    = sat_height(cfg.glyph_height);
    assign gw_p1 = {1'b0, gw} + 5'd1;
    assign gh_p1 = {1'b0, gh} + 5'd1;
    assign tiles = (cfg.tiles_across == '0) ? 9'd1 : cfg.tiles_across;

    assign s_tready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    assign cur_col = s_restart_text ? cfg.origin_column : col_reg;
    assign cur_row = s_restart_text ? cfg.origin_row : row_reg;

    // One restoring step of code modulo tiles
    assign trial  = {rem_reg, code_sh_reg[7]};
    assign tile_x = rem_reg[7:0];
    assign diff   = code_reg - tile_x;

    // Tile start index: tile column plus tile row times tiles across times cell height, times width
    assign base_full = 16'(prod_reg) * 16'(gw);

    // Push loads straight from the input, draws after the tile lookup
    always_comb begin
        q_push                 = 1'b0;
        q_push_data.kind       = CMD_DRAW;
        q_push_data.atlas_addr = ATLAS_AW'(s_atlas_address);
        q_push_data.atlas_bit  = s_atlas_bit;
        q_push_data.col        = draw_col_reg;
        q_push_data.row        = draw_row_reg;
        q_push_data.base       = ATLAS_AW'(base_full);
        if (state_reg == ST_IDLE) begin
            q_push_data.kind = CMD_LOAD;
            q_push           = accept && (s_action == 1'b0);
        end else if (state_reg == ST_PUSH) begin
            q_push = !q_full;
        end
    end

    // Classify items, move the cursor and run the tile lookup
    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        draw_col_next = draw_col_reg;
        draw_row_next = draw_row_reg;
        code_next     = code_reg;
        code_sh_next  = code_sh_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_action) begin
                    priority if (s_char_code == CH_NEWLINE) begin
                        col_next = cfg.origin_column;
                        row_next = cur_row + 16'(gh_p1);
                    end else if (s_char_code == CH_RETURN) begin
                        col_next = cfg.origin_column;
                        row_next = cur_row;
                    end else if (s_char_code == CH_TAB) begin
                        col_next = cur_col + 16'(16'(gw_p1) * 16'(TAB_CELLS));
                        row_next = cur_row;
                    end else begin
                        col_next = cur_col + 16'(gw_p1);
                        row_next = cur_row;
                        if (gw != '0 && gh != '0) begin
                            draw_col_next = cur_col;
                            draw_row_next = cur_row;
                            code_next     = s_char_code;
                            code_sh_next  = s_char_code;
                            rem_next      = '0;
                            cnt_next      = '0;
                            state_next    = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                rem_next     = (trial >= {1'b0, tiles}) ? 9'(trial - {1'b0, tiles})
                                                        : trial[8:0];
                code_sh_next = {code_sh_reg[6:0], 1'b0};
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = 12'(12'(diff) * 12'(gh)) + 12'(tile_x);
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (!q_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
        draw_col_reg <= draw_col_next;
        draw_row_reg <= draw_row_next;
        code_reg     <= code_next;
        code_sh_reg  <= code_sh_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
    end

endmodule

[src/bfr_back.sv]
module bfr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  bfr_pkg::cfg_t  cfg,
    output logic           q_pop,
    input  bfr_pkg::cmd_t  q_pop_data,
    input  logic           q_empty,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [23:0]    m_pixel_address,
    output logic           m_write_enable,
    output logic [31:0]    m_pixel_colour,
    output logic           m_last_of_glyph
);
    import bfr_pkg::*;

    logic                  atlas_mem [ATLAS_PIXELS];

    // Pixel sequencer
    logic                  busy_reg;
    logic [GX_W-1:0]       x_reg;
    logic [GY_W-1:0]       y_reg;
    logic [15:0]           col0_reg;
    logic [15:0]           row0_reg;
    logic [ATLAS_AW-1:0]   atl_row_reg;

    // Address stage and multiply stage
    logic                  b_valid_reg;
    logic [15:0]           b_col_reg;
    logic [15:0]           b_row_reg;
    logic                  b_last_reg;
    logic                  b_bit_reg;
    logic                  c_valid_reg;
    logic [15:0]           c_col_reg;
    logic [23:0]           c_prod_reg;
    logic                  c_bit_reg;
    logic                  c_last_reg;

    // Output register
    logic                  m_valid_reg;
    logic [23:0]           m_addr_reg;
    logic                  m_we_reg;
    logic [31:0]           m_colour_reg;
    logic                  m_last_reg;

    logic                  advance;
    logic [3:0]            gw;
    logic [3:0]            gh;
    logic                  x_end;
    logic                  y_end;
    logic [ATLAS_AW-1:0]   a_idx;
    logic                  load_pop;

    assign gw      = sat_width(cfg.glyph_width);
    assign gh      = sat_height(cfg.glyph_height);
    assign advance = !m_valid_reg || m_ready;
    assign x_end   = (4'(x_reg) == gw - 4'd1);
    assign y_end   = (4'(y_reg) == gh - 4'd1);
    assign a_idx   = atl_row_reg + ATLAS_AW'(x_reg);

    assign q_pop    = !busy_reg && !q_empty;
    assign load_pop = q_pop && (q_pop_data.kind == CMD_LOAD);

    // Take commands and walk the glyph cell in row-major order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (q_pop && q_pop_data.kind == CMD_DRAW) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && advance && x_end && y_end) begin
            busy_reg <= 1'b0;
        end
        if (q_pop) begin
            x_reg       <= '0;
            y_reg       <= '0;
            col0_reg    <= q_pop_data.col;
            row0_reg    <= q_pop_data.row;
            atl_row_reg <= q_pop_data.base;
        end else if (busy_reg && advance) begin
            if (x_end) begin
                x_reg       <= '0;
                y_reg       <= y_reg + 1'b1;
                atl_row_reg <= atl_row_reg + ATLAS_AW'(cfg.atlas_width);
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // Atlas store: loads write, the address stage reads
    always_ff @(posedge aclk) begin
        if (load_pop) begin
            atlas_mem[q_pop_data.atlas_addr] <= q_pop_data.atlas_bit;
        end
        if (advance) begin
            b_bit_reg <= atlas_mem[a_idx];
        end
    end

    // Hold the pipeline while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= busy_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
        if (advance) begin
            b_col_reg    <= col0_reg + 16'(x_reg);
            b_row_reg    <= row0_reg + 16'(y_reg);
            b_last_reg   <= x_end && y_end;
            c_col_reg    <= b_col_reg;
            c_prod_reg   <= 24'(29'(b_row_reg) * 29'(cfg.frame_width));
            c_bit_reg    <= b_bit_reg;
            c_last_reg   <= b_last_reg;
            m_addr_reg   <= c_prod_reg + 24'(c_col_reg);
            m_we_reg     <= c_bit_reg;
            m_colour_reg <= cfg.ink_colour;
            m_last_reg   <= c_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_write_enable  = m_we_reg;
    assign m_pixel_colour  = m_colour_reg;
    assign m_last_of_glyph = m_last_reg;

endmodule
